[rtl/hrd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_pkg: shared types and constants of the response deframer
// Action, phase, result kind and status codes, the frame bytes, and the
// result bundle that the front hands to the back through the queue.
// ----------------------------------------------------------------------------
package hrd_pkg;

   // Payload buffer limit and queue depth
   localparam int MaxPayload = 64;
   localparam int QueueDepth = 2;

   // Frame marker bytes
   localparam logic [7:0] HeaderByte = 8'hAA;
   localparam logic [7:0] MarkerByte = 8'h3C;

   // Timer saturation value
   localparam logic [15:0] TickMax = 16'hFFFF;

   // Configuration register indexes
   localparam logic CsrByteTimeout  = 1'b0;
   localparam logic CsrFrameTimeout = 1'b1;

   typedef enum logic [1:0] {
      ACT_BYTE = 2'd0,
      ACT_TICK = 2'd1,
      ACT_ARM  = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_HEAD    = 4'd1,
      PH_CMD     = 4'd2,
      PH_FIXBODY = 4'd3,
      PH_FIXTAIL = 4'd4,
      PH_VARBODY = 4'd5,
      PH_RESYNC  = 4'd6,
      PH_DRAIN   = 4'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_FAIL    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_BYTE_TIMEOUT   = 3'd1,
      ST_FRAME_TIMEOUT  = 3'd2,
      ST_BAD_TAIL       = 3'd3,
      ST_RESYNC_TIMEOUT = 3'd4
   } status_type;

   // All results caused by one item
   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [2:0]  count;     // number of results, 1 to 4
      logic [1:0]  tail_len;  // broken tail prefix flushed ahead of rx
      logic [7:0]  rx;
      logic [6:0]  base;      // payload count before the first result
      logic        ovf;
      logic [63:0] value;
   } bundle_type;

   // Tail sequence CC 33 C3 3C
   function automatic logic [7:0] tail_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'hCC;
         2'd1:    b = 8'h33;
         2'd2:    b = 8'hC3;
         default: b = 8'h3C;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

[rtl/hrd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_front: frame state machine
// Accepts items, tracks header, command, body and tail, runs the byte and
// frame timers, and pushes one result bundle per item that causes results.
// ----------------------------------------------------------------------------
module hrd_front import hrd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [7:0]  req_expected_command,
   input  wire logic [3:0]  req_fixed_length,
   input  wire logic        queue_full,
   output logic             push,
   output bundle_type       push_data
);

   localparam logic [6:0] MaxCount = 7'(MaxPayload);

   phase_type   phase_ff, phase_in;
   logic [1:0]  tail_ff, tail_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [3:0]  len_ff, len_in;
   logic [6:0]  seen_ff, seen_in;
   logic [63:0] value_ff, value_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] frame_ff, frame_in;
   logic        ovf_ff, ovf_in;
   logic [15:0] byte_to_ff, frame_to_ff;

   logic        fire;
   logic [15:0] idle_sat, frame_sat;
   logic [2:0]  want;
   logic [6:0]  room;
   logic [2:0]  emit_n;

   assign req_ready = !queue_full;
   assign fire      = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_to_ff  <= 16'd100;
         frame_to_ff <= 16'd900;
      end else if (csr_write_enable) begin
         if (csr_index == CsrByteTimeout) byte_to_ff <= csr_write_data;
         if (csr_index == CsrFrameTimeout) frame_to_ff <= csr_write_data;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tail_ff  <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         seen_ff  <= '0;
         value_ff <= '0;
         idle_ff  <= '0;
         frame_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         tail_ff  <= tail_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         value_ff <= value_in;
         idle_ff  <= idle_in;
         frame_ff <= frame_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Saturating timer steps and broken-tail flush sizing
   assign idle_sat  = (idle_ff == TickMax) ? idle_ff : idle_ff + 16'd1;
   assign frame_sat = (frame_ff == TickMax) ? frame_ff : frame_ff + 16'd1;
   assign want      = {1'b0, tail_ff} + 3'd1;
   assign room      = MaxCount - seen_ff;
   assign emit_n    = ({4'b0, want} <= room) ? want : room[2:0];

   // Next state and result bundle
   always_comb begin
      phase_in = phase_ff;
      tail_in  = tail_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      value_in = value_ff;
      idle_in  = idle_ff;
      frame_in = frame_ff;
      ovf_in   = ovf_ff;

      push               = 1'b0;
      push_data.kind     = KIND_FAIL;
      push_data.status   = ST_OK;
      push_data.count    = 3'd1;
      push_data.tail_len = 2'd0;
      push_data.rx       = req_rx_byte;
      push_data.base     = seen_ff;
      push_data.ovf      = ovf_ff;
      push_data.value    = '0;

      if (fire) begin
         case (req_action)
            ACT_BYTE: begin
               case (phase_ff)
                  PH_HEAD: begin
                     idle_in  = '0;
                     phase_in = (req_rx_byte == HeaderByte) ? PH_CMD : PH_RESYNC;
                  end
                  PH_CMD: begin
                     idle_in = '0;
                     if (req_rx_byte == cmd_ff) begin
                        frame_in = '0;
                        tail_in  = '0;
                        phase_in = (len_ff == 4'd0) ? PH_VARBODY : PH_FIXBODY;
                     end else begin
                        phase_in = PH_RESYNC;
                     end
                  end
                  PH_RESYNC: begin
                     if (req_rx_byte == MarkerByte) begin
                        phase_in = PH_HEAD;
                        idle_in  = '0;
                     end
                  end
                  PH_FIXBODY: begin
                     idle_in  = '0;
                     value_in = {value_ff[55:0], req_rx_byte};
                     seen_in  = seen_ff + 7'd1;
                     if (seen_ff + 7'd1 >= {3'b0, len_ff}) begin
                        phase_in = PH_FIXTAIL;
                        tail_in  = '0;
                     end
                  end
                  PH_FIXTAIL: begin
                     idle_in = '0;
                     push    = 1'b1;
                     if (req_rx_byte == tail_byte(tail_ff)) begin
                        if (tail_ff == 2'd3) begin
                           push_data.kind  = KIND_DONE;
                           push_data.value = value_ff;
                           phase_in        = PH_IDLE;
                        end else begin
                           push    = 1'b0;
                           tail_in = tail_ff + 2'd1;
                        end
                     end else begin
                        push_data.status = ST_BAD_TAIL;
                        phase_in = (req_rx_byte == MarkerByte) ? PH_IDLE : PH_DRAIN;
                     end
                  end
                  PH_VARBODY: begin
                     idle_in = '0;
                     if (req_rx_byte == tail_byte(tail_ff)) begin
                        if (tail_ff == 2'd3) begin
                           push           = 1'b1;
                           push_data.kind = KIND_DONE;
                           phase_in       = PH_IDLE;
                        end else begin
                           tail_in = tail_ff + 2'd1;
                        end
                     end else begin
                        // Flush the broken tail prefix and this byte as payload
                        push               = (emit_n != 3'd0);
                        push_data.kind     = KIND_PAYLOAD;
                        push_data.count    = emit_n;
                        push_data.tail_len = tail_ff;
                        seen_in            = seen_ff + {4'b0, emit_n};
                        if (emit_n != want) ovf_in = 1'b1;
                        tail_in = '0;
                     end
                  end
                  PH_DRAIN: begin
                     if (req_rx_byte == MarkerByte) phase_in = PH_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
            ACT_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  idle_in = idle_sat;
                  if (phase_ff == PH_VARBODY) frame_in = frame_sat;
                  if (phase_ff == PH_VARBODY && frame_sat > frame_to_ff) begin
                     push             = 1'b1;
                     push_data.status = ST_FRAME_TIMEOUT;
                     phase_in         = PH_IDLE;
                  end else if (idle_sat > byte_to_ff) begin
                     phase_in = PH_IDLE;
                     if (phase_ff != PH_DRAIN) begin
                        push             = 1'b1;
                        push_data.status = (phase_ff == PH_RESYNC) ? ST_RESYNC_TIMEOUT
                                                                   : ST_BYTE_TIMEOUT;
                     end
                  end
               end
            end
            ACT_ARM: begin
               cmd_in   = req_expected_command;
               len_in   = (req_fixed_length > 4'd8) ? 4'd8 : req_fixed_length;
               phase_in = PH_HEAD;
               tail_in  = '0;
               seen_in  = '0;
               value_in = '0;
               idle_in  = '0;
               frame_in = '0;
               ovf_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/hrd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_queue: bundle queue between front and back
// Two-entry register queue; the head entry is read in place by the back.
// ----------------------------------------------------------------------------
module hrd_queue import hrd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_data,
   input  wire logic       pop,
   output logic            full,
   output logic            empty,
   output bundle_type      head
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [CntW-1:0] DepthCount = CntW'(QueueDepth);

   bundle_type             mem_ff [QueueDepth];
   logic [PtrW-1:0]        wr_ff, wr_in;
   logic [PtrW-1:0]        rd_ff, rd_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;

   assign full  = (cnt_ff == DepthCount);
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? ((wr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DepthCount) else $error("queue count out of range");
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (head.count != 3'd0 && head.count <= 3'd4))
      else $error("queued bundle holds no result");

endmodule
`default_nettype wire

[rtl/hrd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_back: result sequencer
// Walks the head bundle one result item per handshake and pops it after
// its final result.
// ----------------------------------------------------------------------------
module hrd_back import hrd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        empty,
   input  wire bundle_type  head,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_status,
   output logic [6:0]       rsp_payload_count,
   output logic [63:0]      rsp_value,
   output logic             rsp_overflow,
   output logic             rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       is_last;
   logic       take;

   assign rsp_valid = !empty;
   assign take      = rsp_valid && rsp_ready;
   assign is_last   = ({1'b0, idx_ff} == head.count - 3'd1);
   assign pop       = take && is_last;

   // Advance within the bundle, restart on pop
   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

   // Form the current result item
   always_comb begin
      rsp_out_kind      = head.kind;
      rsp_status        = head.status;
      rsp_value         = head.value;
      rsp_overflow      = head.ovf;
      rsp_last          = is_last;
      rsp_payload_byte  = 8'd0;
      rsp_payload_count = head.base;
      if (head.kind == KIND_PAYLOAD) begin
         rsp_payload_byte  = (idx_ff < head.tail_len) ? tail_byte(idx_ff) : head.rx;
         rsp_payload_count = head.base + {5'b0, idx_ff} + 7'd1;
      end
   end

endmodule
`default_nettype wire

[rtl/hmi_response_deframer.sv]
`default_nettype none
// Results: an item's bundle is registered in a 2-bundle queue before its first
// result is offered. Throughput: one item per cycle while the queue is not full;
// an item with k results (at most 4, a flushed broken tail) takes k handshakes.
// Items that cause no result never occupy the result side.
// Reset: synchronous, active high; idles the frame logic, empties the queue and
// loads the byte and frame timeouts with 100 and 900 ticks.
// ----------------------------------------------------------------------------
// hmi_response_deframer: display response frame receiver
// Front state machine, bundle queue and result sequencer.
// ----------------------------------------------------------------------------
module hmi_response_deframer import hrd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [7:0]  req_expected_command,
   input  wire logic [3:0]  req_fixed_length,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_status,
   output logic [6:0]       rsp_payload_count,
   output logic [63:0]      rsp_value,
   output logic             rsp_overflow,
   output logic             rsp_last
);

   logic       push, pop, full, empty;
   bundle_type push_data, head;

   hrd_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_rx_byte          (req_rx_byte),
      .req_expected_command (req_expected_command),
      .req_fixed_length     (req_fixed_length),
      .queue_full           (full),
      .push                 (push),
      .push_data            (push_data)
   );

   hrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   hrd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .empty             (empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_status        (rsp_status),
      .rsp_payload_count (rsp_payload_count),
      .rsp_value         (rsp_value),
      .rsp_overflow      (rsp_overflow),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire
